>>> hw/rtl/adpp_pkg.sv
// shared types, constants and fp32 arithmetic helpers for the row dot prep block
package adpp_pkg;

  localparam logic [31:0] CANON_NAN  = 32'h7FC0_0000;
  localparam logic [31:0] FP32_ONE   = 32'h3F80_0000;
  localparam logic [31:0] FP32_LOG2E = 32'h3FB8_AA3B;
  localparam logic [31:0] SCALE_RST  = 32'h3FB8_AA3B;
  localparam int unsigned RECIP_STEPS = 27;

  // register index codes (paddr bit 2)
  localparam logic REG_AUX_MODE = 1'b0;
  localparam logic REG_SCALE    = 1'b1;

  typedef struct packed {
    logic        done;
    logic [31:0] value;
  } recip_rsp_t;

  // leading zero count over a 50 bit word
  function automatic logic [5:0] lzc50(input logic [49:0] v);
    logic [5:0] n;
    logic       found;
    n = 6'd50;
    found = 1'b0;
    for (int i = 49; i >= 0; i--) begin
      if (!found && v[i]) begin
        n = 6'(49 - i);
        found = 1'b1;
      end
    end
    return n;
  endfunction

  // round to nearest even and pack; sig has its leading one at bit 49
  function automatic logic [31:0] round_pack(input logic sign, input logic signed [11:0] e,
                                             input logic [49:0] sig);
    logic [49:0] s;
    logic [7:0]  ef;
    logic        rnd;
    int          sh;
    s  = sig;
    ef = e[7:0];
    sh = 0;
    if (e >= 12'sd255) begin
      return {sign, 8'hFF, 23'd0};
    end
    if (e <= 12'sd0) begin
      sh = 1 - int'(e);
      ef = 8'd0;
      if (sh >= 50) begin
        s = {49'd0, |sig};
      end else begin
        s = (sig >> sh) | {49'd0, |(sig & ((50'd1 << sh) - 50'd1))};
      end
    end
    rnd = s[25] & ((|s[24:0]) | s[26]);
    return {sign, {ef, s[48:26]} + {30'd0, rnd}};
  endfunction

  // fp16 bits widened to fp32 bits, exact
  function automatic logic [31:0] half_to_f32(input logic [15:0] h);
    logic       s;
    logic [4:0] e;
    logic [9:0] m;
    logic [9:0] mn;
    logic [5:0] lz;
    s = h[15];
    e = h[14:10];
    m = h[9:0];
    lz = lzc50({m, 40'd0});
    mn = 10'(m << (lz + 6'd1));
    if (e == 5'd0) begin
      if (m == 10'd0) return {s, 31'd0};
      return {s, 8'(8'd112 - {2'd0, lz}), mn, 13'd0};
    end
    if (e == 5'd31) return {s, 8'hFF, m, 13'd0};
    return {s, 8'({3'd0, e} + 8'd112), m, 13'd0};
  endfunction

  function automatic logic [31:0] fp32_mul(input logic [31:0] a, input logic [31:0] b);
    logic [7:0]  ea, eb, eaf, ebf;
    logic [23:0] ga, gb;
    logic [47:0] p, pn;
    logic [5:0]  lz;
    logic signed [11:0] e;
    logic        sign, nan_a, nan_b, inf_a, inf_b, zero_a, zero_b;
    ea = a[30:23];
    eb = b[30:23];
    sign   = a[31] ^ b[31];
    nan_a  = (ea == 8'hFF) && (a[22:0] != 23'd0);
    nan_b  = (eb == 8'hFF) && (b[22:0] != 23'd0);
    inf_a  = (ea == 8'hFF) && (a[22:0] == 23'd0);
    inf_b  = (eb == 8'hFF) && (b[22:0] == 23'd0);
    zero_a = (a[30:0] == 31'd0);
    zero_b = (b[30:0] == 31'd0);
    if (nan_a || nan_b || (inf_a && zero_b) || (inf_b && zero_a)) return CANON_NAN;
    if (inf_a || inf_b) return {sign, 8'hFF, 23'd0};
    if (zero_a || zero_b) return {sign, 31'd0};
    eaf = (ea == 8'd0) ? 8'd1 : ea;
    ebf = (eb == 8'd0) ? 8'd1 : eb;
    ga  = {(ea != 8'd0), a[22:0]};
    gb  = {(eb != 8'd0), b[22:0]};
    p   = ga * gb;
    lz  = lzc50({p, 2'd0});
    pn  = p << lz;
    e   = $signed({4'd0, eaf}) + $signed({4'd0, ebf}) - 12'sd126 - $signed({6'd0, lz});
    return round_pack(sign, e, {pn, 2'd0});
  endfunction

  function automatic logic [31:0] fp32_add(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] x, y;
    logic [7:0]  ex, ey, exf, eyf, d;
    logic [26:0] ax, by, bs;
    logic [27:0] r, rn;
    logic [5:0]  lz;
    logic signed [11:0] e;
    logic        nan_a, nan_b, inf_a, inf_b;
    nan_a = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
    nan_b = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    inf_a = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
    inf_b = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
    if (nan_a || nan_b || (inf_a && inf_b && (a[31] != b[31]))) return CANON_NAN;
    if (inf_a) return a;
    if (inf_b) return b;
    if (a[30:0] >= b[30:0]) begin
      x = a;
      y = b;
    end else begin
      x = b;
      y = a;
    end
    ex  = x[30:23];
    ey  = y[30:23];
    exf = (ex == 8'd0) ? 8'd1 : ex;
    eyf = (ey == 8'd0) ? 8'd1 : ey;
    d   = exf - eyf;
    ax  = {(ex != 8'd0), x[22:0], 3'd0};
    by  = {(ey != 8'd0), y[22:0], 3'd0};
    if (d >= 8'd27) begin
      bs = {26'd0, |by};
    end else begin
      bs = (by >> d) | {26'd0, |(by & ((27'd1 << d) - 27'd1))};
    end
    if (x[31] != y[31]) r = {1'b0, ax} - {1'b0, bs};
    else                r = {1'b0, ax} + {1'b0, bs};
    if (r == 28'd0) return {a[31] & b[31], 31'd0};
    lz = lzc50({r, 22'd0});
    rn = r << lz;
    e  = $signed({4'd0, exf}) + 12'sd1 - $signed({6'd0, lz});
    return round_pack(x[31], e, {rn, 22'd0});
  endfunction

endpackage

>>> hw/rtl/adpp_lane.sv
// one lane: exact fp32 product of an fp16 gradient and output pair
module adpp_lane (
  input  logic        clk_i,
  input  logic        load_i,
  input  logic [15:0] grad_i,
  input  logic [15:0] fwd_i,
  output logic [31:0] prod_o
);

  logic [31:0] prod_q;
  logic [31:0] prod_d;

  assign prod_d = adpp_pkg::fp32_mul(adpp_pkg::half_to_f32(grad_i),
                                     adpp_pkg::half_to_f32(fwd_i));

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      prod_q <= prod_d;
    end
  end

  assign prod_o = prod_q;

endmodule

>>> hw/rtl/adpp_recip.sv
// iterative fp32 reciprocal, one quotient bit per cycle, zero in gives zero out
module adpp_recip (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [31:0]            operand_i,
  output adpp_pkg::recip_rsp_t   rsp_o
);

  logic        busy_q, done_q;
  logic [4:0]  cnt_q;
  logic [24:0] rem_q;
  logic [23:0] m_q;
  logic [26:0] quo_q;
  logic signed [11:0] e_q;
  logic        sign_q, spec_q;
  logic [31:0] spec_val_q;

  logic [7:0]  ea, eaf;
  logic [23:0] sig;
  logic [5:0]  lz;
  logic        ge;
  logic        sticky;
  logic signed [11:0] e_out;
  logic [49:0] sig_out;

  assign ea  = operand_i[30:23];
  assign eaf = (ea == 8'd0) ? 8'd1 : ea;
  assign sig = {(ea != 8'd0), operand_i[22:0]};
  assign lz  = adpp_pkg::lzc50({sig, 26'd0});
  assign ge  = (rem_q >= {1'b0, m_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'(adpp_pkg::RECIP_STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      sign_q <= operand_i[31];
      m_q    <= 24'(sig << lz);
      e_q    <= $signed({4'd0, eaf}) - $signed({6'd0, lz});
      rem_q  <= 25'h080_0000;
      quo_q  <= '0;
      spec_q <= (ea == 8'hFF) || (operand_i[30:0] == 31'd0);
      if (ea == 8'hFF && operand_i[22:0] != 23'd0) begin
        spec_val_q <= adpp_pkg::CANON_NAN;
      end else if (ea == 8'hFF) begin
        spec_val_q <= {operand_i[31], 31'd0};
      end else begin
        spec_val_q <= 32'd0;
      end
    end else if (busy_q) begin
      quo_q <= {quo_q[25:0], ge};
      rem_q <= ge ? 25'((rem_q - {1'b0, m_q}) << 1) : 25'(rem_q << 1);
    end
  end

  assign sticky  = (rem_q != 25'd0);
  assign e_out   = quo_q[26] ? (12'sd254 - e_q) : (12'sd253 - e_q);
  assign sig_out = quo_q[26] ? ({quo_q, 23'd0} | {49'd0, sticky})
                             : ({quo_q[25:0], 24'd0} | {49'd0, sticky});

  assign rsp_o.done  = done_q;
  assign rsp_o.value = spec_q ? spec_val_q : adpp_pkg::round_pack(sign_q, e_out, sig_out);

endmodule

>>> hw/rtl/attention_grad_row_dot_prep_core.sv
// top level: row dot product of output gradient and output, plus softmax row statistics
// an item without row end is taken in idle, where the lane products are registered, then gets
// one fp32 add per lane through the single accumulator
// an item with row end adds the reciprocal unit (27 quotient steps, one per cycle) and the
// output load; a finished result waits in the output register while the next row streams in.
// rst_ni clears state, running sum, output valid and the config registers
module attention_grad_row_dot_prep_core #(
  parameter int LANES = 4
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // apb-style config port
  input  logic                    psel_i,
  input  logic                    penable_i,
  input  logic                    pwrite_i,
  input  logic [2:0]              paddr_i,
  input  logic [31:0]             pwdata_i,
  output logic [31:0]             prdata_o,
  output logic                    pready_o,
  // input words
  input  logic                    s_axis_tvalid_i,
  output logic                    s_axis_tready_o,
  // grad_out_0..LANES-1, fwd_out_0..LANES-1 (16 bits each), aux_first, aux_second (32 bits)
  input  logic [LANES*32+63:0]    s_axis_tdata_i,
  input  logic                    s_axis_tlast_i,   // row_end
  // result words
  output logic                    m_axis_tvalid_o,
  input  logic                    m_axis_tready_i,
  // delta, stat_scaled, norm_recip (32 bits each)
  output logic [95:0]             m_axis_tdata_o
);

  localparam int CW = (LANES > 1) ? $clog2(LANES) : 1;
  localparam int AUX_LO = LANES * 32;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_ACC  = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  // config registers
  logic        aux_mode_q;
  logic [31:0] scale_q;
  logic        cfg_wr;

  assign pready_o = 1'b1;
  assign cfg_wr   = psel_i & penable_i & pwrite_i;
  assign prdata_o = (paddr_i[2] == adpp_pkg::REG_SCALE) ? scale_q : {31'd0, aux_mode_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      aux_mode_q <= 1'b0;
      scale_q    <= adpp_pkg::SCALE_RST;
    end else if (cfg_wr) begin
      unique case (paddr_i[2])
        adpp_pkg::REG_AUX_MODE: aux_mode_q <= pwdata_i[0];
        adpp_pkg::REG_SCALE:    scale_q    <= pwdata_i;
        default:                ;
      endcase
    end
  end

  // sequencer
  logic [1:0]    state_q;
  logic [CW-1:0] cnt_q;
  logic          in_fire;
  logic          last_lane;
  logic          row_end_q;
  logic [31:0]   aux_first_q, aux_second_q;
  logic [31:0]   sum_q;
  logic [31:0]   stat_q, norm_q;
  logic          out_valid_q;
  logic [95:0]   out_data_q;
  logic          recip_start;
  logic          out_load;
  adpp_pkg::recip_rsp_t recip_rsp;

  logic [31:0] prod [LANES];

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_fire         = s_axis_tvalid_i & s_axis_tready_o;
  assign last_lane       = (cnt_q == CW'(LANES - 1));
  assign recip_start     = (state_q == ST_ACC) & last_lane & row_end_q;
  // finished row moves into a free or draining output register
  assign out_load        = (state_q == ST_DONE) & (!out_valid_q | m_axis_tready_i);

  // lanes multiply all pairs of the word at once
  for (genvar l = 0; l < LANES; l++) begin : g_lane
    adpp_lane u_lane (
      .clk_i  (clk_i),
      .load_i (in_fire),
      .grad_i (s_axis_tdata_i[16*l +: 16]),
      .fwd_i  (s_axis_tdata_i[LANES*16 + 16*l +: 16]),
      .prod_o (prod[l])
    );
  end

  adpp_recip u_recip (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (recip_start),
    .operand_i (aux_second_q),
    .rsp_o     (recip_rsp)
  );

  // aux fields only matter on a row end, captured with every word
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      aux_first_q  <= s_axis_tdata_i[AUX_LO +: 32];
      aux_second_q <= s_axis_tdata_i[AUX_LO+32 +: 32];
    end
    // stat multiply runs once per word while the adds go on
    if (state_q == ST_ACC && cnt_q == '0) begin
      stat_q <= adpp_pkg::fp32_mul(aux_first_q,
                                   aux_mode_q ? adpp_pkg::FP32_LOG2E : scale_q);
    end
    if (state_q == ST_DIV && recip_rsp.done) begin
      norm_q <= aux_mode_q ? adpp_pkg::FP32_ONE : recip_rsp.value;
    end
    if (out_load) begin
      out_data_q <= {norm_q, stat_q, sum_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      row_end_q   <= 1'b0;
      sum_q       <= 32'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            row_end_q <= s_axis_tlast_i;
            cnt_q     <= '0;
            state_q   <= ST_ACC;
          end
        end
        ST_ACC: begin
          // lane order add into the running sum
          sum_q <= adpp_pkg::fp32_add(sum_q, prod[cnt_q]);
          cnt_q <= cnt_q + CW'(1);
          if (last_lane) begin
            state_q <= row_end_q ? ST_DIV : ST_IDLE;
          end
        end
        ST_DIV: begin
          if (recip_rsp.done) begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          // wait for the output register, then clear the row sum
          if (out_load) begin
            sum_q   <= 32'd0;
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule

>>> hw/rtl/adpp_chk.sv
// port-level checker for the row dot prep core, bound to the top level
module adpp_chk (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 pready_o,
  input logic                 s_axis_tvalid_i,
  input logic                 s_axis_tready_o,
  input logic                 m_axis_tvalid_o,
  input logic                 m_axis_tready_i,
  input logic [95:0]          m_axis_tdata_o
);

  // a stalled result word holds its data
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> (m_axis_tvalid_o && $stable(m_axis_tdata_o)))
    else $error("result word changed while stalled");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready_o)
    else $error("pready dropped");

  // a taken word keeps the input closed while the lanes are summed
  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("input open right after a word");

  // no result appears in the cycle after a word is taken
  a_no_early_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !$rose(m_axis_tvalid_o))
    else $error("result too early");

endmodule

bind attention_grad_row_dot_prep_core adpp_chk u_adpp_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .pready_o        (pready_o),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

>>> verif/tb_attention_grad_row_dot_prep_core.sv
// testbench for the row dot prep core: directed table, random rows, bit-exact fp32 predictor
module tb_attention_grad_row_dot_prep_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NLANE      = 4;
  localparam int DW         = NLANE * 32 + 64;
  localparam int SETTLE     = 60;        // a bit above the row end latency of the core
  localparam int MAX_CYCLES = 1000000;
  localparam logic [31:0] FP_LOG2E = 32'h3FB8_AA3B;
  localparam logic [31:0] CANON_NAN    = adpp_pkg::CANON_NAN;
  localparam logic [31:0] FP32_ONE     = adpp_pkg::FP32_ONE;
  localparam logic [31:0] SCALE_RST    = adpp_pkg::SCALE_RST;
  localparam logic        REG_AUX_MODE = adpp_pkg::REG_AUX_MODE;
  localparam logic        REG_SCALE    = adpp_pkg::REG_SCALE;

  // one input word and one result word
  typedef struct {
    logic [15:0] grad [NLANE];
    logic [15:0] fwd  [NLANE];
    logic [31:0] aux_first;
    logic [31:0] aux_second;
    logic        row_end;
  } elem_word_t;

  typedef struct packed {
    logic [31:0] delta;
    logic [31:0] stat_scaled;
    logic [31:0] norm_recip;
  } row_stats_t;

  // directed row: optional hand-typed result
  typedef struct {
    logic [15:0] g0, f0, g1, f1;
    logic [31:0] a1, a2;
    logic        last;
    logic        typed;
    row_stats_t  res;
  } dir_row_t;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            psel_i = 1'b0, penable_i = 1'b0, pwrite_i = 1'b0;
  logic [2:0]      paddr_i = '0;
  logic [31:0]     pwdata_i = '0;
  logic [31:0]     prdata_o;
  logic            pready_o;
  logic            s_axis_tvalid_i = 1'b0;
  logic            s_axis_tready_o;
  logic [DW-1:0]   s_axis_tdata_i = '0;   // grad 0..3, fwd 0..3, aux_first, aux_second
  logic            s_axis_tlast_i = 1'b0;  // row_end
  logic            m_axis_tvalid_o;
  logic            m_axis_tready_i = 1'b0;
  logic [95:0]     m_axis_tdata_o;          // delta, stat_scaled, norm_recip

  // predictor state and register copies
  logic [31:0]     row_sum;
  logic            cfg_mode;
  logic [31:0]     cfg_scale;
  row_stats_t      pending_rows [$];
  int              mismatches = 0;
  int              cycles = 0;
  bit              long_hold = 1'b0;
  bit              no_idle = 1'b0;

  attention_grad_row_dot_prep_core #(.LANES(NLANE)) dut (.*);

  always #6 clk_i = ~clk_i;

  // ---------------------------------------------------------------
  // fp32 arithmetic, exact integer math then a single rounding
  // ---------------------------------------------------------------

  // value = sgn * m * 2^e2, m may carry a sticky bit far below the round bit
  function automatic logic [31:0] fp_round(logic sgn, int e2, logic [127:0] m);
    logic [255:0] w, kept, rem, half;
    int ex, sh;
    if (m == '0) return {sgn, 31'd0};
    while (!m[127]) begin
      m = m << 1;
      e2--;
    end
    ex = e2 + 127 + 127;
    if (ex >= 255) return {sgn, 8'hFF, 23'd0};
    sh = 104 + ((ex <= 0) ? 1 - ex : 0);
    if (sh > 200) sh = 200;
    w    = {128'd0, m};
    kept = w >> sh;
    rem  = w & ((256'd1 << sh) - 256'd1);
    half = 256'd1 << (sh - 1);
    if (rem > half || (rem == half && kept[0])) kept = kept + 256'd1;
    if (ex <= 0) return {sgn, kept[30:0]};
    return {sgn, 31'((ex - 1) << 23) + kept[30:0]};
  endfunction

  function automatic logic is_nan(logic [31:0] a);
    return a[30:23] == 8'hFF && a[22:0] != '0;
  endfunction

  function automatic logic is_inf(logic [31:0] a);
    return a[30:23] == 8'hFF && a[22:0] == '0;
  endfunction

  function automatic logic [23:0] sig_of(logic [31:0] a);
    return {a[30:23] != 8'd0, a[22:0]};
  endfunction

  function automatic int exp_of(logic [31:0] a);
    return ((a[30:23] == 8'd0) ? 1 : int'(a[30:23])) - 150;
  endfunction

  // fp16 widened exactly by value
  function automatic logic [31:0] widen_half(logic [15:0] h);
    logic [127:0] m;
    if (h[14:10] == 5'h1F) return {h[15], 8'hFF, h[9:0], 13'd0};
    m = {117'd0, h[14:10] != 5'd0, h[9:0]};
    return fp_round(h[15], ((h[14:10] == 5'd0) ? 1 : int'(h[14:10])) - 25, m);
  endfunction

  function automatic logic [31:0] fp_mul(logic [31:0] a, logic [31:0] b);
    logic sgn;
    logic zero_a, zero_b;
    sgn = a[31] ^ b[31];
    zero_a = a[30:0] == '0;
    zero_b = b[30:0] == '0;
    if (is_nan(a) || is_nan(b) || (is_inf(a) && zero_b) || (is_inf(b) && zero_a))
      return CANON_NAN;
    if (is_inf(a) || is_inf(b)) return {sgn, 8'hFF, 23'd0};
    return fp_round(sgn, exp_of(a) + exp_of(b), 128'(sig_of(a)) * 128'(sig_of(b)));
  endfunction

  function automatic logic [31:0] fp_add(logic [31:0] a, logic [31:0] b);
    logic [31:0]  x, y;
    logic [127:0] mx, my, full, r;
    int d;
    if (is_nan(a) || is_nan(b) || (is_inf(a) && is_inf(b) && a[31] != b[31]))
      return CANON_NAN;
    if (is_inf(a)) return a;
    if (is_inf(b)) return b;
    if (a[30:0] >= b[30:0]) begin
      x = a;
      y = b;
    end else begin
      x = b;
      y = a;
    end
    d  = exp_of(x) - exp_of(y);
    mx = 128'(sig_of(x)) << 60;
    full = 128'(sig_of(y)) << 60;
    if (d >= 90) my = 128'(full != '0);
    else my = (full >> d) | 128'((full & ((128'd1 << d) - 128'd1)) != '0);
    r = (x[31] != y[31]) ? mx - my : mx + my;
    if (r == '0) return {a[31] & b[31], 31'd0};
    return fp_round(x[31], exp_of(x) - 60, r);
  endfunction

  // softmax normalizer, a zero sum of either sign gives +0
  function automatic logic [31:0] fp_recip(logic [31:0] a);
    logic [127:0] num, q, m;
    if (is_nan(a)) return CANON_NAN;
    if (a[30:0] == '0) return 32'd0;
    if (is_inf(a)) return {a[31], 31'd0};
    num = 128'd1 << 120;
    q = num / 128'(sig_of(a));
    m = (q << 1) | 128'((num % 128'(sig_of(a))) != '0);
    return fp_round(a[31], -121 - exp_of(a), m);
  endfunction

  // running sum update and, on a row end, the row statistics
  function automatic logic predict_row(elem_word_t w, output row_stats_t res);
    logic [31:0] acc;
    acc = row_sum;
    for (int i = 0; i < NLANE; i++)
      acc = fp_add(acc, fp_mul(widen_half(w.grad[i]), widen_half(w.fwd[i])));
    row_sum = acc;
    res = '0;
    if (!w.row_end) return 1'b0;
    res.delta = acc;
    if (cfg_mode) begin
      res.stat_scaled = fp_mul(w.aux_first, FP_LOG2E);
      res.norm_recip  = FP32_ONE;
    end else begin
      res.stat_scaled = fp_mul(w.aux_first, cfg_scale);
      res.norm_recip  = fp_recip(w.aux_second);
    end
    row_sum = 32'd0;
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------
  // random values
  // ---------------------------------------------------------------
  function automatic logic [15:0] rand_half();
    int r;
    r = $urandom_range(0, 99);
    if (r < 2)  return {1'($urandom), 5'h1F, 10'($urandom)};
    if (r < 8)  return {1'($urandom), 15'd0};
    if (r < 15) return {1'($urandom), 5'd0, 10'($urandom)};
    if (r < 30) return 16'($urandom);
    return {1'($urandom), 5'($urandom_range(8, 22)), 10'($urandom)};
  endfunction

  function automatic logic [31:0] rand_single();
    int r;
    r = $urandom_range(0, 99);
    if (r < 4)  return {1'($urandom), 8'hFF, 23'($urandom_range(0, 1) ? $urandom : 0)};
    if (r < 12) return {1'($urandom), 31'd0};
    if (r < 20) return {1'($urandom), 8'd0, 23'($urandom)};
    if (r < 45) return $urandom;
    return {1'($urandom), 8'($urandom_range(100, 154)), 23'($urandom)};
  endfunction

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // ---------------------------------------------------------------
  // bus drivers
  // ---------------------------------------------------------------
  task automatic reg_write(logic idx, logic [31:0] val);
    @(posedge clk_i);
    psel_i   <= 1'b1;
    pwrite_i <= 1'b1;
    penable_i <= 1'b0;
    paddr_i  <= {idx, 2'b00};
    pwdata_i <= val;
    @(posedge clk_i);
    penable_i <= 1'b1;
    @(posedge clk_i);
    // register takes the value at this edge
    psel_i <= 1'b0;
    penable_i <= 1'b0;
    pwrite_i <= 1'b0;
    if (idx == REG_AUX_MODE) cfg_mode = val[0];
    else cfg_scale = val;
  endtask

  // offer one word, wait for the handshake, then record what it should produce
  task automatic push_word(elem_word_t w, logic typed, row_stats_t typed_res);
    logic [DW-1:0] bus;
    row_stats_t    res;
    int            gap;
    for (int i = 0; i < NLANE; i++) begin
      bus[16*i +: 16]         = w.grad[i];
      bus[16*(NLANE+i) +: 16] = w.fwd[i];
    end
    bus[NLANE*32 +: 32]      = w.aux_first;
    bus[NLANE*32 + 32 +: 32] = w.aux_second;
    s_axis_tdata_i  <= bus;
    s_axis_tlast_i  <= w.row_end;
    s_axis_tvalid_i <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    if (predict_row(w, res)) pending_rows.push_back(typed ? typed_res : res);
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // block idle: every result back, then the row end latency
  task automatic drain();
    @(posedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (pending_rows.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // random rows, about half of them long rows of 32 words, the rest short ones of 1 to 8 words
  task automatic random_rows(int n_words);
    elem_word_t w;
    row_stats_t dummy;
    int len, k;
    dummy = '0;
    while (n_words > 0) begin
      len = ($urandom_range(0, 1) == 0) ? 32 : $urandom_range(1, 8);
      for (k = 0; k < len && n_words > 0; k++) begin
        for (int i = 0; i < NLANE; i++) begin
          w.grad[i] = rand_half();
          w.fwd[i]  = rand_half();
        end
        w.aux_first  = rand_single();
        w.aux_second = rand_single();
        w.row_end    = (k == len - 1) || (n_words == 1);
        push_word(w, 1'b0, dummy);
        n_words--;
      end
    end
  endtask

  // ---------------------------------------------------------------
  // result side
  // ---------------------------------------------------------------
  initial begin
    int r;
    forever begin
      @(posedge clk_i);
      if (long_hold) begin
        // long stall so the core fills up and holds off its input
        m_axis_tready_i <= 1'b0;
        repeat (400) @(posedge clk_i);
        long_hold = 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (no_idle || r < 60) m_axis_tready_i <= 1'b1;
        else begin
          m_axis_tready_i <= 1'b0;
          repeat ((r < 95) ? $urandom_range(0, 3) : $urandom_range(20, 60)) @(posedge clk_i);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    row_stats_t got, want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = {m_axis_tdata_o[31:0], m_axis_tdata_o[63:32], m_axis_tdata_o[95:64]};
      if (pending_rows.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %h", m_axis_tdata_o);
      end else begin
        want = pending_rows.pop_front();
        if (got.delta != want.delta || got.stat_scaled != want.stat_scaled ||
            got.norm_recip != want.norm_recip) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch delta %h/%h stat %h/%h norm %h/%h (exp/act)",
                     want.delta, got.delta, want.stat_scaled, got.stat_scaled,
                     want.norm_recip, got.norm_recip);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > MAX_CYCLES) begin
      $display("status: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------
  initial begin
    dir_row_t    dir_tab [];
    elem_word_t  w;
    logic [31:0] scales [7];
    logic        modes  [7];
    row_sum   = 32'd0;
    cfg_mode  = 1'b0;
    cfg_scale = SCALE_RST;
    // g0 f0 g1 f1 aux_first aux_second last typed {delta stat norm}
    dir_tab = '{
      // all zero row end, zero sum gives +0 normalizer
      '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 32'h0, 32'h0, 1'b1, 1'b1, '0},
      // 1*1, unit sum
      '{16'h3C00, 16'h3C00, 16'h0000, 16'h0000, 32'h0, FP32_ONE, 1'b1, 1'b1,
        '{FP32_ONE, 32'h0, FP32_ONE}},
      // negative zero sum also gives +0
      '{16'h3C00, 16'hBC00, 16'h0000, 16'h0000, 32'h0, 32'h8000_0000, 1'b1, 1'b1,
        '{32'hBF80_0000, 32'h0, 32'h0}},
      // fp16 nan in, canonical nan out
      '{16'h7E01, 16'h3C00, 16'h0000, 16'h0000, 32'h0, FP32_ONE, 1'b1, 1'b1,
        '{CANON_NAN, 32'h0, FP32_ONE}},
      // inf times zero
      '{16'h7C00, 16'h0000, 16'h0000, 16'h0000, 32'hFFC0_0001, FP32_ONE, 1'b1, 1'b1,
        '{CANON_NAN, CANON_NAN, FP32_ONE}},
      // +inf and -inf in one row
      '{16'h7C00, 16'h3C00, 16'hFC00, 16'h3C00, 32'h7F80_0000, 32'h7F80_0000, 1'b1, 1'b1,
        '{CANON_NAN, 32'h7F80_0000, 32'h0}},
      // largest magnitudes, row spread over several words
      '{16'h7BFF, 16'h7BFF, 16'hFBFF, 16'h7BFF, 32'h7F7F_FFFF, 32'h7F7F_FFFF, 1'b0, 1'b0, '0},
      '{16'h7BFF, 16'h7BFF, 16'h7BFF, 16'h7BFF, 32'h0, 32'h0, 1'b0, 1'b0, '0},
      '{16'hFFFF, 16'h0001, 16'h8001, 16'h8001, 32'h7F7F_FFFF, 32'h0000_0001, 1'b1, 1'b0, '0},
      // subnormal products, tiny reciprocal overflow
      '{16'h0001, 16'h0001, 16'h03FF, 16'h83FF, 32'h0000_0001, 32'h0000_0001, 1'b1, 1'b0, '0},
      '{16'h0400, 16'h0400, 16'h8400, 16'h0401, 32'h807F_FFFF, 32'h8000_0001, 1'b1, 1'b0, '0},
      // cancellation and rounding ties
      '{16'h3C01, 16'h3C01, 16'hBC02, 16'h3C00, 32'h3F80_0000, 32'h4040_0000, 1'b0, 1'b0, '0},
      '{16'h1400, 16'h1400, 16'h5BFF, 16'h5BFF, 32'hC2C8_0000, 32'h3EAA_AAAB, 1'b1, 1'b0, '0},
      // single word rows of raw bit patterns
      '{16'hFFFF, 16'hFFFF, 16'hAAAA, 16'h5555, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0, '0},
      '{16'h5555, 16'hAAAA, 16'h0000, 16'hFFFF, 32'h5555_5555, 32'hAAAA_AAAA, 1'b1, 1'b0, '0}
    };
    scales = '{32'h3E38_AA3B, 32'h0000_0000, 32'hFFFF_FFFF, 32'h7F7F_FFFF,
               32'h0000_0001, 32'h8000_0000, 32'h0};
    modes  = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1};
    scales[6] = $urandom;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (4) @(posedge clk_i);

    // directed table at register reset values
    foreach (dir_tab[t]) begin
      w.grad = '{dir_tab[t].g0, dir_tab[t].g1, 16'h0000, 16'h0000};
      w.fwd  = '{dir_tab[t].f0, dir_tab[t].f1, 16'h0000, 16'h0000};
      if (t >= 13) begin
        w.grad[2] = dir_tab[t].g0;
        w.grad[3] = dir_tab[t].g1;
        w.fwd[2]  = dir_tab[t].f0;
        w.fwd[3]  = dir_tab[t].f1;
      end
      w.aux_first  = dir_tab[t].a1;
      w.aux_second = dir_tab[t].a2;
      w.row_end    = dir_tab[t].last;
      push_word(w, dir_tab[t].typed, dir_tab[t].res);
    end
    drain();

    // random phases over several register settings
    for (int p = 0; p < 7; p++) begin
      reg_write(REG_AUX_MODE, {31'd0, modes[p]});
      reg_write(REG_SCALE, scales[p]);
      no_idle = (p == 3);
      if (p == 2) long_hold = 1'b1;
      random_rows(125);
      drain();
    end

    if (mismatches == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
